// ----- rtl/lbsalu_pkg.sv -----
// Shared types, operation codes and status bit constants for the logic, bit and shift unit.
package lbsalu_pkg;

    // Operation codes
    localparam logic [4:0] CMD_ORI  = 5'd0;
    localparam logic [4:0] CMD_ANDI = 5'd1;
    localparam logic [4:0] CMD_EORI = 5'd2;
    localparam logic [4:0] CMD_BTST = 5'd3;
    localparam logic [4:0] CMD_BCHG = 5'd4;
    localparam logic [4:0] CMD_BCLR = 5'd5;
    localparam logic [4:0] CMD_BSET = 5'd6;
    localparam logic [4:0] CMD_NOT  = 5'd7;
    localparam logic [4:0] CMD_TST  = 5'd8;
    localparam logic [4:0] CMD_TAS  = 5'd9;
    localparam logic [4:0] CMD_ASR  = 5'd10;
    localparam logic [4:0] CMD_LSR  = 5'd11;
    localparam logic [4:0] CMD_ROXR = 5'd12;
    localparam logic [4:0] CMD_ROR  = 5'd13;
    localparam logic [4:0] CMD_ASL  = 5'd14;
    localparam logic [4:0] CMD_LSL  = 5'd15;
    localparam logic [4:0] CMD_ROXL = 5'd16;
    localparam logic [4:0] CMD_ROL  = 5'd17;

    // Operand sizes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;
    localparam logic [1:0] SIZE_BAD  = 2'd3;

    // Exception codes
    localparam logic [1:0] EXC_NONE      = 2'd0;
    localparam logic [1:0] EXC_PRIVILEGE = 2'd1;
    localparam logic [1:0] EXC_ILLEGAL   = 2'd2;

    // Destination that selects the status register form
    localparam logic [2:0] MODE_DREG   = 3'd0;
    localparam logic [2:0] MODE_SPEC   = 3'd7;
    localparam logic [2:0] REG_SRFORM  = 3'd4;

    // Status register bit positions and masks
    localparam int FLAG_C = 0;
    localparam int FLAG_V = 1;
    localparam int FLAG_Z = 2;
    localparam int FLAG_N = 3;
    localparam int FLAG_X = 4;
    localparam int SR_SUPER = 13;
    localparam logic [15:0] SR_MASK  = 16'hF71F;
    localparam logic [7:0]  CCR_MASK = 8'h1F;
    localparam logic [7:0]  TAS_BIT  = 8'h80;

    // One input beat
    typedef struct packed {
        logic [4:0]  cmd;
        logic [1:0]  size;
        logic [2:0]  ea_mode;
        logic [2:0]  ea_register;
        logic [31:0] operand;
        logic [31:0] immediate;
        logic [15:0] status_in;
    } t_item;

    // One result beat
    typedef struct packed {
        logic [31:0] result;
        logic [15:0] status_out;
        logic        write_back;
        logic [1:0]  exception;
    } t_result;

    // Mask of the bits that exist at an operand size.
    function automatic logic [31:0] size_mask(input logic [1:0] sz);
        logic [31:0] m;
        begin
            m = 32'hFFFF_FFFF;
            if (sz == SIZE_BYTE) m = 32'h0000_00FF;
            else if (sz == SIZE_WORD) m = 32'h0000_FFFF;
            return m;
        end
    endfunction

    // Sign bit at an operand size.
    function automatic logic [31:0] size_sign(input logic [1:0] sz);
        logic [31:0] m;
        begin
            m = 32'h8000_0000;
            if (sz == SIZE_BYTE) m = 32'h0000_0080;
            else if (sz == SIZE_WORD) m = 32'h0000_8000;
            return m;
        end
    endfunction

    // Set N and Z from a value, clear V and C, keep everything else.
    function automatic logic [15:0] nz_flags(input logic [15:0] sr, input logic [31:0] v,
                                             input logic [1:0] sz);
        logic [15:0] s;
        begin
            s = sr;
            s[FLAG_C] = 1'b0;
            s[FLAG_V] = 1'b0;
            s[FLAG_Z] = ((v & size_mask(sz)) == 32'd0);
            s[FLAG_N] = ((v & size_sign(sz)) != 32'd0);
            return s;
        end
    endfunction

    // OR, AND or EOR selected by the operation code.
    function automatic logic [31:0] logic_op(input logic [4:0] cmd, input logic [31:0] a,
                                             input logic [31:0] b);
        logic [31:0] r;
        begin
            r = a ^ b;
            if (cmd == CMD_ORI) r = a | b;
            else if (cmd == CMD_ANDI) r = a & b;
            return r;
        end
    endfunction

endpackage

// ----- rtl/lbsalu_exec.sv -----
// Combinational execute logic: one logic, bit or shift instruction to one result.
module lbsalu_exec (
    input  lbsalu_pkg::t_item   i_item,
    output lbsalu_pkg::t_result o_res
);
    import lbsalu_pkg::*;

    logic        srform;
    logic [15:0] sr;
    logic [31:0] res;
    logic [15:0] nsr;
    logic        wb;
    logic [1:0]  exc;
    logic [31:0] ccr_val;
    logic [31:0] sr_val;
    logic [4:0]  bn;
    logic [31:0] bv;
    logic [31:0] bmask;
    logic [15:0] sv;
    logic [15:0] sres;
    logic        xin;
    logic        cout;
    logic        vf;
    logic        setx;

    assign srform = (i_item.ea_mode == MODE_SPEC) && (i_item.ea_register == REG_SRFORM);
    assign sr     = i_item.status_in;

    // Status register forms of the logic immediates.
    assign ccr_val = logic_op(i_item.cmd, {24'd0, sr[7:0]}, {24'd0, i_item.immediate[7:0]});
    assign sr_val  = logic_op(i_item.cmd, {16'd0, sr}, {16'd0, i_item.immediate[15:0]});

    // Bit number and operand width depend on register or memory destination.
    assign bn    = (i_item.ea_mode == MODE_DREG) ? i_item.immediate[4:0]
                                                 : {2'b00, i_item.immediate[2:0]};
    assign bv    = (i_item.ea_mode == MODE_DREG) ? i_item.operand
                                                 : {24'd0, i_item.operand[7:0]};
    assign bmask = 32'd1 << bn;

    // Memory shifts and rotates: one place on a word.
    assign sv  = i_item.operand[15:0];
    assign xin = sr[FLAG_X];

    always_comb begin
        sres = {sv[15], sv[15:1]};
        cout = sv[0];
        vf   = 1'b0;
        setx = 1'b1;
        unique case (i_item.cmd)
            CMD_ASR:  begin sres = {sv[15], sv[15:1]}; cout = sv[0]; end
            CMD_LSR:  begin sres = {1'b0, sv[15:1]};   cout = sv[0]; end
            CMD_ROXR: begin sres = {xin, sv[15:1]};    cout = sv[0]; end
            CMD_ROR:  begin sres = {sv[0], sv[15:1]};  cout = sv[0]; setx = 1'b0; end
            CMD_ASL:  begin
                sres = {sv[14:0], 1'b0};
                cout = sv[15];
                vf   = sv[15] ^ sv[14];
            end
            CMD_LSL:  begin sres = {sv[14:0], 1'b0};   cout = sv[15]; end
            CMD_ROXL: begin sres = {sv[14:0], xin};    cout = sv[15]; end
            CMD_ROL:  begin sres = {sv[14:0], sv[15]}; cout = sv[15]; setx = 1'b0; end
            default:  begin sres = {sv[15], sv[15:1]}; cout = sv[0]; end
        endcase
    end

    // Instruction decode and flag update.
    always_comb begin
        res = 32'd0;
        nsr = sr;
        wb  = 1'b0;
        exc = EXC_NONE;
        priority if (i_item.cmd > CMD_ROL) begin
            exc = EXC_ILLEGAL;
        end else if (i_item.cmd <= CMD_EORI) begin
            if (i_item.size == SIZE_BAD || (srform && i_item.size == SIZE_LONG)) begin
                exc = EXC_ILLEGAL;
            end else if (srform && i_item.size == SIZE_BYTE) begin
                nsr = {sr[15:8], ccr_val[7:0] & CCR_MASK};
            end else if (srform) begin
                if (!sr[SR_SUPER]) exc = EXC_PRIVILEGE;
                else nsr = sr_val[15:0] & SR_MASK;
            end else begin
                res = logic_op(i_item.cmd, i_item.operand, i_item.immediate)
                      & size_mask(i_item.size);
                nsr = nz_flags(sr, res, i_item.size);
                wb  = 1'b1;
            end
        end else if (srform) begin
            exc = EXC_ILLEGAL;
        end else if (i_item.cmd <= CMD_BSET) begin
            nsr[FLAG_Z] = ((bv & bmask) == 32'd0);
            if (i_item.cmd != CMD_BTST) begin
                wb = 1'b1;
                if (i_item.cmd == CMD_BCHG) res = bv ^ bmask;
                else if (i_item.cmd == CMD_BCLR) res = bv & ~bmask;
                else res = bv | bmask;
            end
        end else if (i_item.cmd == CMD_NOT || i_item.cmd == CMD_TST) begin
            if (i_item.size == SIZE_BAD) begin
                exc = EXC_ILLEGAL;
            end else if (i_item.cmd == CMD_NOT) begin
                res = ~i_item.operand & size_mask(i_item.size);
                nsr = nz_flags(sr, res, i_item.size);
                wb  = 1'b1;
            end else begin
                nsr = nz_flags(sr, i_item.operand, i_item.size);
            end
        end else if (i_item.cmd == CMD_TAS) begin
            nsr = nz_flags(sr, {24'd0, i_item.operand[7:0]}, SIZE_BYTE);
            res = {24'd0, i_item.operand[7:0] | TAS_BIT};
            wb  = 1'b1;
        end else begin
            res = {16'd0, sres};
            nsr = nz_flags(sr, {16'd0, sres}, SIZE_WORD);
            nsr[FLAG_C] = cout;
            nsr[FLAG_V] = vf;
            if (setx) nsr[FLAG_X] = cout;
            wb  = 1'b1;
        end

        // An exception leaves the status alone and stores nothing.
        if (exc != EXC_NONE) begin
            res = 32'd0;
            nsr = sr;
            wb  = 1'b0;
        end
    end

    assign o_res.result     = res;
    assign o_res.status_out = nsr;
    assign o_res.write_back = wb;
    assign o_res.exception  = exc;

endmodule

// ----- rtl/cpu_logic_bit_shift_alu.sv -----
// Top level of the logic, bit and shift unit: input register, execute logic, result register.
// An accepted beat is held in the input register; its result is then captured in the result register.
// Throughput: one beat per cycle unless stalled; the execute logic between the registers is single pass.
// The input register can take one more beat while a finished result waits; once both hold
// beats, o_stall follows i_stall in the same cycle until the downstream side takes the result.
// Reset (synchronous, active low) empties both registers; payload registers are not cleared.
module cpu_logic_bit_shift_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [4:0]  i_cmd,
    input  logic [1:0]  i_size,
    input  logic [2:0]  i_ea_mode,
    input  logic [2:0]  i_ea_register,
    input  logic [31:0] i_operand,
    input  logic [31:0] i_immediate,
    input  logic [15:0] i_status_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result,
    output logic [15:0] o_status_out,
    output logic        o_write_back,
    output logic [1:0]  o_exception
);
    import lbsalu_pkg::*;

    logic    r_in_valid;
    logic    n_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;
    t_result exec_res;
    logic    out_ready;
    logic    in_ready;
    logic    in_take;
    logic    out_load;

    // Handshake: the result register frees when empty or taken, the input register behind it.
    assign out_ready = !r_out_valid || !i_stall;
    assign in_ready  = !r_in_valid || out_ready;
    assign o_stall   = !in_ready;
    assign in_take   = i_valid && in_ready;
    assign out_load  = r_in_valid && out_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) n_in_valid = 1'b1;
        else if (out_ready) n_in_valid = 1'b0;
        n_out_valid = r_out_valid;
        if (out_ready) n_out_valid = r_in_valid;
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Input register captures an accepted beat.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.cmd         <= i_cmd;
            r_in.size        <= i_size;
            r_in.ea_mode     <= i_ea_mode;
            r_in.ea_register <= i_ea_register;
            r_in.operand     <= i_operand;
            r_in.immediate   <= i_immediate;
            r_in.status_in   <= i_status_in;
        end
    end

    lbsalu_exec u_exec (
        .i_item (r_in),
        .o_res  (exec_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= exec_res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_result     = r_out.result;
    assign o_status_out = r_out.status_out;
    assign o_write_back = r_out.write_back;
    assign o_exception  = r_out.exception;

    // A waiting input beat stays put while the result register is blocked.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_ready |=> r_in_valid && $stable(r_in))
        else $error("input register lost or changed a waiting beat");

    // A beat that is stored or that raises an exception never does both.
    a_wb_exc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_write_back |-> o_exception == EXC_NONE)
        else $error("write-back with exception");

    // Nothing to store means a zero result.
    a_nowb_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_write_back |-> o_result == 32'd0)
        else $error("nonzero result without write-back");

    // A result beat only appears after an input beat was held.
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid && !r_in_valid |=> !r_out_valid)
        else $error("result beat without input beat");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the logic, bit and shift unit: a directed table, then random instructions.
module testbench;
    import lbsalu_pkg::*;

    // Operation codes past the last defined one
    localparam logic [4:0] CMD_FIRST_BAD = 5'd18;
    localparam logic [4:0] CMD_LAST_BAD  = 5'd31;
    // Memory addressing modes used by the directed rows
    localparam logic [2:0] MODE_AIND  = 3'd2;
    localparam logic [2:0] MODE_ADISP = 3'd5;

    localparam int RANDOM_BEATS = 850;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int HOLD_CYCLES  = 60;

    typedef struct {
        t_item   beat;
        bit      typed;
        t_result want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [4:0]  i_cmd;
    logic [1:0]  i_size;
    logic [2:0]  i_ea_mode;
    logic [2:0]  i_ea_register;
    logic [31:0] i_operand;
    logic [31:0] i_immediate;
    logic [15:0] i_status_in;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_result;
    logic [15:0] o_status_out;
    logic        o_write_back;
    logic [1:0]  o_exception;

    t_row    directed_plan[$];
    t_result pending_outcomes[$];
    bit      calm = 1'b0;
    int      results_seen = 0;
    int      stores_seen = 0;
    int      traps_seen = 0;
    int      mismatches = 0;
    int      cycle_count = 0;

    cpu_logic_bit_shift_alu i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_size        (i_size),
        .i_ea_mode     (i_ea_mode),
        .i_ea_register (i_ea_register),
        .i_operand     (i_operand),
        .i_immediate   (i_immediate),
        .i_status_in   (i_status_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result      (o_result),
        .o_status_out  (o_status_out),
        .o_write_back  (o_write_back),
        .o_exception   (o_exception)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bits that exist at an operand size.
    function automatic logic [31:0] size_bits(input logic [1:0] sz);
        case (sz)
            SIZE_BYTE: return 32'h0000_00FF;
            SIZE_WORD: return 32'h0000_FFFF;
            default:   return 32'hFFFF_FFFF;
        endcase
    endfunction

    // N and Z follow the value at its size, V and C clear, the rest stays.
    function automatic logic [15:0] flags_from_value(input logic [15:0] sr, input logic [31:0] v,
                                                     input logic [1:0] sz);
        logic [31:0] w;
        logic [15:0] s;
        w = v & size_bits(sz);
        s = sr;
        s[FLAG_C] = 1'b0;
        s[FLAG_V] = 1'b0;
        s[FLAG_Z] = (w == 32'd0);
        case (sz)
            SIZE_BYTE: s[FLAG_N] = w[7];
            SIZE_WORD: s[FLAG_N] = w[15];
            default:   s[FLAG_N] = w[31];
        endcase
        return s;
    endfunction

    function automatic logic [31:0] logic_combine(input logic [4:0] cmd, input logic [31:0] a,
                                                  input logic [31:0] b);
        case (cmd)
            CMD_ORI:  return a | b;
            CMD_ANDI: return a & b;
            default:  return a ^ b;
        endcase
    endfunction

    // Outcome of one instruction: stored value, new status, write-back and trap code.
    function automatic t_result exec_outcome(input t_item it);
        t_result     o;
        logic        srform;
        logic [31:0] v;
        logic [31:0] bitmask;
        logic [31:0] t;
        logic [15:0] sr;
        logic [15:0] v16;
        logic [15:0] sh;
        logic [4:0]  bn;
        logic        xin;
        logic        cout;
        logic        vf;
        logic        setx;
        sr = it.status_in;
        o.result = 32'd0;
        o.status_out = sr;
        o.write_back = 1'b0;
        o.exception = EXC_NONE;
        srform = (it.ea_mode == MODE_SPEC) && (it.ea_register == REG_SRFORM);
        if (it.cmd > CMD_ROL) begin
            o.exception = EXC_ILLEGAL;
        end else if (it.cmd <= CMD_EORI) begin
            if (it.size == SIZE_BAD || (srform && it.size == SIZE_LONG)) begin
                o.exception = EXC_ILLEGAL;
            end else if (srform && it.size == SIZE_BYTE) begin
                // Condition code form: only the five flag bits of the low byte exist.
                t = logic_combine(it.cmd, {24'd0, sr[7:0]}, {24'd0, it.immediate[7:0]});
                o.status_out = {sr[15:8], t[7:0] & CCR_MASK};
            end else if (srform) begin
                if (!sr[SR_SUPER]) begin
                    o.exception = EXC_PRIVILEGE;
                end else begin
                    t = logic_combine(it.cmd, {16'd0, sr}, {16'd0, it.immediate[15:0]});
                    o.status_out = t[15:0] & SR_MASK;
                end
            end else begin
                o.result = logic_combine(it.cmd, it.operand, it.immediate) & size_bits(it.size);
                o.status_out = flags_from_value(sr, o.result, it.size);
                o.write_back = 1'b1;
            end
        end else if (srform) begin
            o.exception = EXC_ILLEGAL;
        end else if (it.cmd <= CMD_BSET) begin
            // Bit number wraps at 32 on a data register and at 8 on memory.
            bn = (it.ea_mode == MODE_DREG) ? it.immediate[4:0] : {2'b00, it.immediate[2:0]};
            v = (it.ea_mode == MODE_DREG) ? it.operand : {24'd0, it.operand[7:0]};
            bitmask = 32'd1 << bn;
            o.status_out[FLAG_Z] = ((v & bitmask) == 32'd0);
            if (it.cmd != CMD_BTST) begin
                case (it.cmd)
                    CMD_BCHG: v = v ^ bitmask;
                    CMD_BCLR: v = v & ~bitmask;
                    default:  v = v | bitmask;
                endcase
                o.result = v;
                o.write_back = 1'b1;
            end
        end else if (it.cmd == CMD_NOT || it.cmd == CMD_TST) begin
            if (it.size == SIZE_BAD) begin
                o.exception = EXC_ILLEGAL;
            end else if (it.cmd == CMD_NOT) begin
                o.result = ~it.operand & size_bits(it.size);
                o.status_out = flags_from_value(sr, o.result, it.size);
                o.write_back = 1'b1;
            end else begin
                o.status_out = flags_from_value(sr, it.operand, it.size);
            end
        end else if (it.cmd == CMD_TAS) begin
            o.status_out = flags_from_value(sr, {24'd0, it.operand[7:0]}, SIZE_BYTE);
            o.result = {24'd0, it.operand[7:0] | TAS_BIT};
            o.write_back = 1'b1;
        end else begin
            // Memory shifts and rotates move a word by one place.
            v16 = it.operand[15:0];
            xin = sr[FLAG_X];
            vf = 1'b0;
            setx = 1'b1;
            cout = v16[0];
            case (it.cmd)
                CMD_ASR:  sh = {v16[15], v16[15:1]};
                CMD_LSR:  sh = {1'b0, v16[15:1]};
                CMD_ROXR: sh = {xin, v16[15:1]};
                CMD_ROR: begin
                    sh = {v16[0], v16[15:1]};
                    setx = 1'b0;
                end
                CMD_ASL: begin
                    sh = {v16[14:0], 1'b0};
                    cout = v16[15];
                    vf = v16[15] ^ v16[14];
                end
                CMD_LSL: begin
                    sh = {v16[14:0], 1'b0};
                    cout = v16[15];
                end
                CMD_ROXL: begin
                    sh = {v16[14:0], xin};
                    cout = v16[15];
                end
                default: begin
                    sh = {v16[14:0], v16[15]};
                    cout = v16[15];
                    setx = 1'b0;
                end
            endcase
            o.result = {16'd0, sh};
            o.status_out = flags_from_value(sr, o.result, SIZE_WORD);
            o.status_out[FLAG_C] = cout;
            o.status_out[FLAG_V] = vf;
            if (setx) o.status_out[FLAG_X] = cout;
            o.write_back = 1'b1;
        end
        if (o.exception != EXC_NONE) begin
            o.result = 32'd0;
            o.status_out = sr;
            o.write_back = 1'b0;
        end
        return o;
    endfunction

    // Add a directed row whose outcome comes from the predictor.
    task automatic plan_row(input logic [4:0] cmd, input logic [1:0] size, input logic [2:0] mode,
                            input logic [2:0] rn, input logic [31:0] opnd,
                            input logic [31:0] imm, input logic [15:0] sr);
        t_row r;
        r.beat.cmd = cmd;
        r.beat.size = size;
        r.beat.ea_mode = mode;
        r.beat.ea_register = rn;
        r.beat.operand = opnd;
        r.beat.immediate = imm;
        r.beat.status_in = sr;
        r.typed = 1'b0;
        r.want = '0;
        directed_plan.push_back(r);
    endtask

    // Pin a hand-written outcome on the most recent directed row.
    task automatic plan_known(input logic [31:0] res, input logic [15:0] sro, input logic wb,
                              input logic [1:0] exc);
        t_row r;
        r = directed_plan.pop_back();
        r.typed = 1'b1;
        r.want.result = res;
        r.want.status_out = sro;
        r.want.write_back = wb;
        r.want.exception = exc;
        directed_plan.push_back(r);
    endtask

    // Random instruction with biased operands and a share of bad codes and status forms.
    function automatic t_item roll_beat();
        t_item b;
        if ($urandom_range(0, 99) < 4) b.cmd = 5'($urandom_range(CMD_FIRST_BAD, CMD_LAST_BAD));
        else b.cmd = 5'($urandom_range(CMD_ORI, CMD_ROL));
        if ($urandom_range(0, 99) < 8) b.size = SIZE_BAD;
        else b.size = 2'($urandom_range(SIZE_BYTE, SIZE_LONG));
        if ($urandom_range(0, 99) < 12) begin
            b.ea_mode = MODE_SPEC;
            b.ea_register = REG_SRFORM;
        end else begin
            b.ea_mode = 3'($urandom_range(0, 7));
            b.ea_register = 3'($urandom_range(0, 7));
        end
        case ($urandom_range(0, 5))
            0:       b.operand = 32'h0000_0000;
            1:       b.operand = 32'hFFFF_FFFF;
            2:       b.operand = 32'd1 << $urandom_range(0, 31);
            default: b.operand = $urandom;
        endcase
        b.immediate = $urandom;
        b.status_in = 16'($urandom_range(0, 16'hFFFF));
        return b;
    endfunction

    // Offer one beat after a random gap and hold it until the unit takes it.
    task automatic send_beat(input t_item b, input t_result want);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 34) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= b.cmd;
        i_size <= b.size;
        i_ea_mode <= b.ea_mode;
        i_ea_register <= b.ea_register;
        i_operand <= b.operand;
        i_immediate <= b.immediate;
        i_status_in <= b.status_in;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_outcomes.push_back(want);
    endtask

    // Stop offering until every outstanding result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // Sender: reset, the directed table, then random instructions.
    initial begin
        t_item b;
        int    n;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = CMD_ORI;
        i_size = SIZE_BYTE;
        i_ea_mode = MODE_DREG;
        i_ea_register = 3'd0;
        i_operand = 32'd0;
        i_immediate = 32'd0;
        i_status_in = 16'd0;

        plan_row(CMD_ORI, SIZE_BYTE, MODE_DREG, 3'd0, 32'h0000_0000, 32'h0000_0000, 16'h0000);
        plan_known(32'h0000_0000, 16'h0004, 1'b1, EXC_NONE);
        plan_row(CMD_ANDI, SIZE_LONG, MODE_DREG, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h001F);
        plan_known(32'hFFFF_FFFF, 16'h0018, 1'b1, EXC_NONE);
        plan_row(CMD_EORI, SIZE_WORD, MODE_AIND, 3'd3, 32'h0000_1234, 32'h0000_1234, 16'h0008);
        plan_known(32'h0000_0000, 16'h0004, 1'b1, EXC_NONE);
        // Condition code and status register forms
        plan_row(CMD_ORI, SIZE_BYTE, MODE_SPEC, REG_SRFORM, 32'h0, 32'h0000_00FF, 16'hA700);
        plan_known(32'h0, 16'hA71F, 1'b0, EXC_NONE);
        plan_row(CMD_ANDI, SIZE_WORD, MODE_SPEC, REG_SRFORM, 32'h0, 32'h0000_FFFF, 16'hFFFF);
        plan_known(32'h0, 16'hF71F, 1'b0, EXC_NONE);
        plan_row(CMD_EORI, SIZE_WORD, MODE_SPEC, REG_SRFORM, 32'h0, 32'h0000_2000, 16'h071F);
        plan_known(32'h0, 16'h071F, 1'b0, EXC_PRIVILEGE);
        plan_row(CMD_ORI, SIZE_LONG, MODE_SPEC, REG_SRFORM, 32'h0, 32'h0000_0001, 16'h2700);
        plan_known(32'h0, 16'h2700, 1'b0, EXC_ILLEGAL);
        // Illegal sizes, status forms and operation codes
        plan_row(CMD_ANDI, SIZE_BAD, MODE_DREG, 3'd1, 32'h1234_5678, 32'h0, 16'h0015);
        plan_known(32'h0, 16'h0015, 1'b0, EXC_ILLEGAL);
        plan_row(CMD_BTST, SIZE_BYTE, MODE_SPEC, REG_SRFORM, 32'hFF, 32'h0, 16'h2000);
        plan_known(32'h0, 16'h2000, 1'b0, EXC_ILLEGAL);
        plan_row(CMD_FIRST_BAD, SIZE_WORD, MODE_DREG, 3'd0, 32'h5555_AAAA, 32'h1, 16'h0000);
        plan_known(32'h0, 16'h0000, 1'b0, EXC_ILLEGAL);
        plan_row(CMD_LAST_BAD, SIZE_LONG, MODE_SPEC, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        plan_known(32'h0, 16'hFFFF, 1'b0, EXC_ILLEGAL);
        plan_row(CMD_NOT, SIZE_BAD, MODE_DREG, 3'd2, 32'h0, 32'h0, 16'h1234);
        plan_known(32'h0, 16'h1234, 1'b0, EXC_ILLEGAL);
        // Bit operations on a data register and on memory
        plan_row(CMD_BTST, SIZE_LONG, MODE_DREG, 3'd0, 32'h8000_0000, 32'd31, 16'h0004);
        plan_row(CMD_BCHG, SIZE_BYTE, MODE_AIND, 3'd1, 32'hFFFF_FF00, 32'hFFFF_FFFF, 16'h0000);
        plan_row(CMD_BCLR, SIZE_LONG, MODE_DREG, 3'd5, 32'hFFFF_FFFF, 32'd0, 16'h001B);
        plan_row(CMD_BSET, SIZE_WORD, MODE_ADISP, 3'd6, 32'h0000_0000, 32'd8, 16'h001F);
        // Single-operand instructions
        plan_row(CMD_NOT, SIZE_BYTE, MODE_DREG, 3'd0, 32'h0000_00FF, 32'h0, 16'h0000);
        plan_row(CMD_NOT, SIZE_LONG, MODE_AIND, 3'd4, 32'h0000_0000, 32'h0, 16'h0017);
        plan_row(CMD_TST, SIZE_WORD, MODE_DREG, 3'd3, 32'hFFFF_8000, 32'h0, 16'h0013);
        plan_row(CMD_TAS, SIZE_BAD, MODE_ADISP, 3'd2, 32'h0000_007F, 32'h0, 16'h000F);
        // Word shifts and rotates
        plan_row(CMD_ASR, SIZE_WORD, MODE_AIND, 3'd0, 32'h0000_8001, 32'h0, 16'h0000);
        plan_row(CMD_LSR, SIZE_WORD, MODE_AIND, 3'd0, 32'h0000_0001, 32'h0, 16'h0000);
        plan_row(CMD_ROXR, SIZE_WORD, MODE_AIND, 3'd1, 32'h0000_0000, 32'h0, 16'h0010);
        plan_row(CMD_ROR, SIZE_WORD, MODE_AIND, 3'd1, 32'h0000_0001, 32'h0, 16'h0000);
        plan_row(CMD_ASL, SIZE_WORD, MODE_ADISP, 3'd2, 32'h0000_4000, 32'h0, 16'h0000);
        plan_row(CMD_LSL, SIZE_WORD, MODE_ADISP, 3'd2, 32'hFFFF_8000, 32'h0, 16'h0000);
        plan_row(CMD_ROXL, SIZE_WORD, MODE_ADISP, 3'd3, 32'h0000_FFFF, 32'h0, 16'h0010);
        plan_row(CMD_ROL, SIZE_BAD, MODE_ADISP, 3'd3, 32'h0000_8000, 32'h0, 16'h0000);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < directed_plan.size(); n++) begin
            send_beat(directed_plan[n].beat,
                      directed_plan[n].typed ? directed_plan[n].want
                                             : exec_outcome(directed_plan[n].beat));
        end
        wait_drained();

        for (n = 0; n < RANDOM_BEATS; n++) begin
            // A stretch of back-to-back traffic on both sides.
            calm = (n >= 400 && n < 480);
            if (n == 300) wait_drained();
            b = roll_beat();
            send_beat(b, exec_outcome(b));
        end
        calm = 1'b0;
        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("Ran %0d directed and %0d random instructions through the unit.",
                 directed_plan.size(), RANDOM_BEATS);
        $display("Checked %0d results: %0d stores, %0d traps, %0d mismatching fields.",
                 results_seen, stores_seen, traps_seen, mismatches);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Receiver: random stalls, plus long holds that back the unit up into its input.
    initial begin
        int hold_left;
        int next_hold;
        hold_left = 0;
        next_hold = 150;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && results_seen >= next_hold) begin
                hold_left = HOLD_CYCLES;
                next_hold += 450;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= (!calm && $urandom_range(0, 99) < 34);
            end
        end
    end

    // Compare each accepted result beat with the oldest outstanding outcome.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_outcomes.size() == 0) begin
                $error("result beat with nothing outstanding: result %h status %h",
                       o_result, o_status_out);
                mismatches++;
            end else begin
                want = pending_outcomes.pop_front();
                results_seen++;
                if (want.write_back) stores_seen++;
                if (want.exception != EXC_NONE) traps_seen++;
                if (o_result !== want.result) begin
                    $error("result: expected %h, got %h", want.result, o_result);
                    mismatches++;
                end
                if (o_status_out !== want.status_out) begin
                    $error("status_out: expected %h, got %h", want.status_out, o_status_out);
                    mismatches++;
                end
                if (o_write_back !== want.write_back) begin
                    $error("write_back: expected %b, got %b", want.write_back, o_write_back);
                    mismatches++;
                end
                if (o_exception !== want.exception) begin
                    $error("exception: expected %0d, got %0d", want.exception, o_exception);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
